[design/sst_pkg.sv]
// Package for the scoped symbol table: sizes, operation and status codes,
// sequencer states. Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package sst_pkg;
  localparam int MaxEntries   = 256;
  localparam int MaxScopes    = 32;
  localparam int NameChars    = 8;
  localparam int IdxW         = $clog2(MaxEntries);
  localparam int CntW         = $clog2(MaxEntries + 1);
  localparam int ScopeW       = $clog2(MaxScopes);
  localparam int NameW        = NameChars * 8;
  localparam logic [7:0]  DepthMax  = 8'd255;
  localparam logic [16:0] OffsetMax = 17'd65535;

  typedef enum logic [2:0] {
    OP_CLEAR = 3'd0, OP_ENTER = 3'd1, OP_LEAVE = 3'd2,
    OP_DECLARE = 3'd3, OP_RESOLVE = 3'd4, OP_READ = 3'd5
  } op_t;

  typedef enum logic [2:0] {
    ST_OK = 3'd0, ST_REDECL = 3'd1, ST_FULL = 3'd2,
    ST_OVERFLOW = 3'd3, ST_NOT_FOUND = 3'd4, ST_DEPTH_SAT = 3'd5
  } status_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_SCAN  = 6'b000010,
    S_WAIT  = 6'b000100,
    S_CHECK = 6'b001000,
    S_FETCH = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  // one entry as held in the table memory
  typedef struct packed {
    logic [NameW-1:0] name;
    logic [3:0]       tcode;
    logic [15:0]      offset;
    logic [7:0]       size;
    logic [7:0]       depth;
  } entry_t;

  // memory access from the sequencer
  typedef struct packed {
    logic          rd;
    logic [IdxW-1:0] raddr;
    logic          wr;
    logic [IdxW-1:0] waddr;
    entry_t        wdata;
    logic          act_wr;
    logic [IdxW-1:0] act_addr;
    logic          act_val;
  } mem_req_t;
endpackage

[design/sst_store.sv]
// Entry store of the symbol table: entry fields in one memory, active bits in
// another, both with registered read data. Depends on sst_pkg.
`timescale 1ns / 1ps
module sst_store (
  input  logic            clk,
  input  sst_pkg::mem_req_t req,
  output sst_pkg::entry_t rdata,
  output logic            ract
);
  sst_pkg::entry_t mem [sst_pkg::MaxEntries];
  logic            act [sst_pkg::MaxEntries];

  always_ff @(posedge clk) begin
    if (req.wr) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.rd) begin
      rdata <= mem[req.raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (req.act_wr) begin
      act[req.act_addr] <= req.act_val;
    end
    if (req.rd) begin
      ract <= act[req.raddr];
    end
  end
endmodule

[design/scoped_symbol_table.sv]
// Scoped symbol table, top level: sequencer, comparator and result register.
// Clear, enter and unused codes go straight to the result; read fetches the entry first;
// declare, resolve and leave scan the entries (read, then compare), newest first, and
// then pass through a check state before the result.
// One transaction at a time; in_stall is high from acceptance until taken.
// Reset (rst, synchronous) zeroes count, offset, depth; memories are not cleared.
`timescale 1ns / 1ps
module scoped_symbol_table (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  mode,
  input  logic [63:0] name_key,
  input  logic [3:0]  type_code,
  input  logic [7:0]  type_size,
  input  logic [7:0]  entry_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [7:0]  found_index,
  output logic [15:0] found_offset,
  output logic [7:0]  found_size,
  output logic [3:0]  found_type,
  output logic [7:0]  found_depth,
  output logic        found_active,
  output logic [15:0] frame_total,
  output logic [7:0]  current_depth
);
  localparam int IdxW = sst_pkg::IdxW;
  localparam int CntW = sst_pkg::CntW;

  sst_pkg::state_t state, state_next;
  logic [CntW-1:0] count;
  logic [15:0]     free_off;
  logic [7:0]      depth;
  logic [8:0]      marks [sst_pkg::MaxScopes];

  sst_pkg::op_t           op;
  logic [sst_pkg::NameW-1:0] key;
  logic [3:0]  tcode;
  logic [7:0]  tsize;
  logic [CntW-1:0] scan;   // one above the next entry to read, counts down
  logic [CntW-1:0] lo;     // lowest entry the scan visits
  logic [IdxW-1:0] cur;    // entry whose data is in the read register
  logic        hit;

  sst_pkg::mem_req_t req;
  sst_pkg::entry_t   rdata;
  logic              ract;

  sst_store u_store (.clk(clk), .req(req), .rdata(rdata), .ract(ract));

  logic match;
  always_comb begin
    match = 1'b0;
    case (op)
      sst_pkg::OP_DECLARE: match = ract && rdata.depth == depth && rdata.name == key;
      sst_pkg::OP_RESOLVE: match = ract && rdata.name == key;
      default:             match = 1'b0;
    endcase
  end

  logic scanning;
  assign scanning = (state == sst_pkg::S_SCAN) && (scan > lo);
  logic [16:0] new_end;
  assign new_end = {1'b0, free_off} + {9'd0, tsize};

  always_comb begin
    req = '0;
    req.rd    = scanning;
    req.raddr = IdxW'(scan - CntW'(1));
    if (state == sst_pkg::S_IDLE && in_valid && mode == sst_pkg::OP_READ) begin
      req.rd    = 1'b1;
      req.raddr = entry_index[IdxW-1:0];
    end
    if (state == sst_pkg::S_WAIT && op == sst_pkg::OP_LEAVE && !hit &&
        rdata.depth == depth + 8'd1) begin
      req.act_wr   = 1'b1;
      req.act_addr = cur;
      req.act_val  = 1'b0;
    end
    if (state == sst_pkg::S_CHECK && op == sst_pkg::OP_DECLARE && !hit &&
        count < CntW'(sst_pkg::MaxEntries) && new_end <= sst_pkg::OffsetMax) begin
      req.wr       = 1'b1;
      req.waddr    = count[IdxW-1:0];
      req.wdata    = '{name: key, tcode: tcode, offset: free_off, size: tsize,
                       depth: depth};
      req.act_wr   = 1'b1;
      req.act_addr = count[IdxW-1:0];
      req.act_val  = 1'b1;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      sst_pkg::S_IDLE:  if (in_valid) begin
        state_next = sst_pkg::S_DONE;
        if (mode == sst_pkg::OP_LEAVE || mode == sst_pkg::OP_DECLARE ||
            mode == sst_pkg::OP_RESOLVE) state_next = sst_pkg::S_SCAN;
        if (mode == sst_pkg::OP_READ) state_next = sst_pkg::S_FETCH;
      end
      sst_pkg::S_SCAN:  state_next = scanning ? sst_pkg::S_WAIT : sst_pkg::S_CHECK;
      sst_pkg::S_WAIT:  state_next = sst_pkg::S_SCAN;
      sst_pkg::S_CHECK: state_next = sst_pkg::S_DONE;
      sst_pkg::S_FETCH: state_next = sst_pkg::S_DONE;
      sst_pkg::S_DONE:  if (!out_stall) state_next = sst_pkg::S_IDLE;
      default:          state_next = sst_pkg::S_IDLE;
    endcase
  end

  assign in_stall  = state != sst_pkg::S_IDLE;
  assign out_valid = state == sst_pkg::S_DONE;

  // scope mark memory, written on enter
  logic [8:0] mark_rd;
  always_ff @(posedge clk) begin
    if (state == sst_pkg::S_IDLE && in_valid && mode == sst_pkg::OP_ENTER &&
        depth < sst_pkg::DepthMax && {1'b0, depth} < 9'(sst_pkg::MaxScopes)) begin
      marks[depth[sst_pkg::ScopeW-1:0]] <= 9'(count);
    end
    mark_rd <= marks[sst_pkg::ScopeW'(depth - 8'd1)];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sst_pkg::S_IDLE;
      count <= '0;
      free_off <= '0;
      depth <= '0;
    end else begin
      state <= state_next;
      case (state)
        sst_pkg::S_IDLE: if (in_valid) begin
          op <= sst_pkg::op_t'(mode);
          key <= name_key[sst_pkg::NameW-1:0];
          tcode <= type_code;
          tsize <= type_size;
          hit <= 1'b0;
          // a leave at depth zero scans nothing
          scan <= (mode == sst_pkg::OP_LEAVE && depth == 8'd0) ? '0 : count;
          lo <= '0;
          cur <= entry_index[IdxW-1:0];
          {found_index, found_offset, found_size, found_type,
           found_depth, found_active} <= '0;
          case (mode)
            sst_pkg::OP_CLEAR: begin
              count <= '0; free_off <= '0; depth <= '0;
              status <= sst_pkg::ST_OK;
            end
            sst_pkg::OP_ENTER: begin
              if (depth >= sst_pkg::DepthMax) status <= sst_pkg::ST_DEPTH_SAT;
              else begin
                depth <= depth + 8'd1;
                status <= sst_pkg::ST_OK;
              end
            end
            sst_pkg::OP_LEAVE: begin
              if (depth != 8'd0) depth <= depth - 8'd1;
              status <= sst_pkg::ST_OK;
            end
            sst_pkg::OP_RESOLVE: status <= sst_pkg::ST_NOT_FOUND;
            sst_pkg::OP_READ: status <= ({1'b0, entry_index} >= 9'(count)) ?
                                        sst_pkg::ST_NOT_FOUND : sst_pkg::ST_OK;
            default: status <= sst_pkg::ST_OK;
          endcase
        end
        sst_pkg::S_SCAN: begin
          // leave: bound the scan by the mark of the scope being left, read at acceptance
          if (op == sst_pkg::OP_LEAVE && scan == count && lo == '0 &&
              {1'b0, depth} < 9'(sst_pkg::MaxScopes)) begin
            lo <= (mark_rd > 9'(count)) ? count : CntW'(mark_rd);
          end
          if (scanning) begin
            cur  <= IdxW'(scan - CntW'(1));
            scan <= scan - CntW'(1);
          end
        end
        sst_pkg::S_WAIT: begin
          if (match && !hit) begin
            hit <= 1'b1;
            scan <= '0;
            status <= (op == sst_pkg::OP_DECLARE) ? sst_pkg::ST_REDECL : sst_pkg::ST_OK;
            found_index <= 8'(cur); found_offset <= rdata.offset;
            found_size <= rdata.size; found_type <= rdata.tcode;
            found_depth <= rdata.depth; found_active <= ract;
          end
        end
        sst_pkg::S_CHECK: if (op == sst_pkg::OP_DECLARE && !hit) begin
          if (count >= CntW'(sst_pkg::MaxEntries)) status <= sst_pkg::ST_FULL;
          else if (new_end > sst_pkg::OffsetMax) status <= sst_pkg::ST_OVERFLOW;
          else begin
            status <= sst_pkg::ST_OK;
            found_index <= 8'(count); found_offset <= free_off;
            found_size <= tsize; found_type <= tcode;
            found_depth <= depth; found_active <= 1'b1;
            free_off <= new_end[15:0];
            count <= count + CntW'(1);
          end
        end
        sst_pkg::S_FETCH: if (status == sst_pkg::ST_OK) begin
          found_index <= 8'(cur); found_offset <= rdata.offset;
          found_size <= rdata.size; found_type <= rdata.tcode;
          found_depth <= rdata.depth; found_active <= ract;
        end
        default: ;
      endcase
    end
  end

  assign frame_total   = free_off;
  assign current_depth = depth;

  // leave reads the mark of the scope being left at acceptance, so the bound
  // lands after the first scan step; that step still reads the newest entry
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CntW'(sst_pkg::MaxEntries)) else $error("entry count beyond table");
  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall) else $error("input open while result pending");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(status))
    else $error("result dropped while stalled");
  a_single_write: assert property (@(posedge clk) disable iff (rst)
    req.wr |-> state == sst_pkg::S_CHECK) else $error("write outside commit");
endmodule
